// ===== rtl/avsc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the AIS VDO sentence checker: character codes, term limits,
// the result struct and small decode functions. It depends on nothing else.
package avsc_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned TermKeep = 5;
  localparam int unsigned OffsW = 3;
  localparam int unsigned TermW = 3;

  localparam logic [OffsW-1:0] OffsKeep = OffsW'(TermKeep);
  localparam logic [OffsW-1:0] OffsLong = OffsW'(6);
  localparam logic [TermW-1:0] TermLimit = TermW'(6);
  localparam logic [TermW-1:0] TermPayload = TermW'(5);
  localparam logic [TermW-1:0] TermType = TermW'(0);

  localparam logic [CharW-1:0] ChStart = 8'h21;
  localparam logic [CharW-1:0] ChComma = 8'h2C;
  localparam logic [CharW-1:0] ChStar = 8'h2A;
  localparam logic [CharW-1:0] ChCr = 8'h0D;
  localparam logic [CharW-1:0] ChLf = 8'h0A;
  localparam logic [CharW-1:0] ChZero = 8'h30;
  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChLowerA = 8'h61;
  localparam logic [CharW-1:0] ChV = 8'h56;
  localparam logic [CharW-1:0] ChD = 8'h44;
  localparam logic [CharW-1:0] ChO = 8'h4F;

  typedef struct packed {
    logic             sentence_ok;
    logic             payload_valid;
    logic [CharW-1:0] payload_char;
  } avsc_result_t;

  function automatic logic [CharW-1:0] hex_value(input logic [CharW-1:0] code);
    logic [CharW-1:0] val;
    if (code inside {[8'h41:8'h46]}) begin
      val = code - ChUpperA + 8'd10;
    end else if (code inside {[8'h61:8'h66]}) begin
      val = code - ChLowerA + 8'd10;
    end else begin
      val = code - ChZero;
    end
    return val;
  endfunction

  function automatic logic is_upper(input logic [CharW-1:0] code);
    return code inside {[8'h41:8'h5A]};
  endfunction

endpackage

// ===== rtl/avsc_parser.sv =====
`timescale 1ns / 1ps
// Sentence state and the combinational update for one character.
// Depends on avsc_pkg for codes, limits, decode functions and the result struct.
module avsc_parser import avsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CharW-1:0] char_i,
  output avsc_result_t     res_o
);

  logic [CharW-1:0] xor_q, xor_d;
  logic [TermW-1:0] term_q, term_d;
  logic [OffsW-1:0] offs_q, offs_d;
  logic [CharW-1:0] first_q [TermKeep];
  logic             in_ck_q, in_ck_d;
  logic             type_q, type_d;
  logic             wr_en;

  logic [CharW-1:0] ck_hi, ck_lo, ck_sum;
  logic [CharW-1:0] hi_val, lo_val;
  logic             type_hit;
  logic             is_delim;

  always_comb begin
    ck_hi  = (offs_q > OffsW'(0)) ? first_q[0] : '0;
    ck_lo  = (offs_q > OffsW'(1)) ? first_q[1] : '0;
    hi_val = hex_value(ck_hi);
    lo_val = hex_value(ck_lo);
    ck_sum = {hi_val[3:0], 4'b0000} + lo_val;
    type_hit = (offs_q == OffsKeep) && is_upper(first_q[0]) && is_upper(first_q[1]) &&
               (first_q[2] == ChV) && (first_q[3] == ChD) && (first_q[4] == ChO);
    is_delim = char_i inside {ChComma, ChCr, ChLf, ChStar};
  end

  always_comb begin
    xor_d   = xor_q;
    term_d  = term_q;
    offs_d  = offs_q;
    in_ck_d = in_ck_q;
    type_d  = type_q;
    wr_en   = 1'b0;
    res_o   = '0;
    if (is_delim) begin
      if ((char_i == ChComma) && !in_ck_q) begin
        xor_d = xor_q ^ char_i;
      end
      if (in_ck_q) begin
        res_o.sentence_ok = (ck_sum == xor_q) && type_q;
      end else if ((term_q == TermType) && type_hit) begin
        type_d = 1'b1;
      end
      if (term_q < TermLimit) begin
        term_d = term_q + TermW'(1);
      end
      offs_d  = '0;
      in_ck_d = (char_i == ChStar);
    end else if (char_i == ChStart) begin
      type_d  = 1'b0;
      term_d  = '0;
      offs_d  = '0;
      xor_d   = '0;
      in_ck_d = 1'b0;
    end else begin
      if (offs_q < OffsKeep) begin
        wr_en  = 1'b1;
        offs_d = offs_q + OffsW'(1);
      end else begin
        offs_d = OffsLong;
      end
      if (!in_ck_q) begin
        xor_d = xor_q ^ char_i;
        if (type_q && (term_q == TermPayload)) begin
          res_o.payload_valid = 1'b1;
          res_o.payload_char  = char_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q   <= '0;
      term_q  <= '0;
      offs_q  <= '0;
      in_ck_q <= 1'b0;
      type_q  <= 1'b0;
      for (int i = 0; i < TermKeep; i++) begin
        first_q[i] <= '0;
      end
    end else if (step_i) begin
      xor_q   <= xor_d;
      term_q  <= term_d;
      offs_q  <= offs_d;
      in_ck_q <= in_ck_d;
      type_q  <= type_d;
      if (wr_en) begin
        first_q[offs_q] <= char_i;
      end
    end
  end

endmodule

// ===== rtl/ais_vdo_sentence_checker_unit.sv =====
`timescale 1ns / 1ps
// Top level of the AIS VDO sentence checker: input register, parser and
// result register. Depends on avsc_pkg and avsc_parser.
//
//   Channel  Signals                                         Direction
//   input    valid_i, stall_o, char_in_i                     into block
//   result   valid_o, stall_i, sentence_ok_o,
//            payload_valid_o, payload_char_o                 out of block
//
// One character is taken per cycle while stall_o is low; a result passes through the
// input register and then the result register, and transfers out while valid_o is high
// and stall_i is low.
// The parser state updates in the cycle a character moves into the result register.
// Reset clears the sentence state and both valid flags.
// A stalled result holds; the input register still takes one more character.
module ais_vdo_sentence_checker_unit import avsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [CharW-1:0] char_in_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic             sentence_ok_o,
  output logic             payload_valid_o,
  output logic [CharW-1:0] payload_char_o
);

  logic             in_vld_q;
  logic [CharW-1:0] in_char_q;
  logic             out_vld_q;
  avsc_result_t     out_res_q;
  avsc_result_t     res;
  logic             move;
  logic             take;

  assign move    = in_vld_q && (!out_vld_q || !stall_i);
  assign stall_o = in_vld_q && !move;
  assign take    = valid_i && !stall_o;

  avsc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (move),
    .char_i (in_char_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        in_vld_q <= 1'b1;
      end else if (move) begin
        in_vld_q <= 1'b0;
      end
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (!stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_char_q <= char_in_i;
    end
    if (move) begin
      out_res_q <= res;
    end
  end

  assign valid_o         = out_vld_q;
  assign sentence_ok_o   = out_res_q.sentence_ok;
  assign payload_valid_o = out_res_q.payload_valid;
  assign payload_char_o  = out_res_q.payload_char;

endmodule

// ===== sim/ais_vdo_sentence_checker_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ais_vdo_sentence_checker_unit. It runs a short directed
// sentence and then random sentences and noise, and checks every result in order.
// It depends on avsc_pkg and the RTL of the checker.
module ais_vdo_sentence_checker_unit_test;
  import avsc_pkg::*;

  localparam int DirN = 23;
  localparam int RandItems = 1250;
  localparam int DrainCycles = 10;
  localparam int CycleLimit = 600000;

  localparam logic [CharW-1:0] ChNul = 8'h00;
  localparam logic [CharW-1:0] ChUpperF = 8'h46;
  localparam logic [CharW-1:0] ChUpperZ = 8'h5A;
  localparam logic [CharW-1:0] ChLowerF = 8'h66;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             typed;
    avsc_result_t     want;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             valid_i = 1'b0;
  logic             stall_o;
  logic [CharW-1:0] char_in_i = '0;
  logic             valid_o;
  logic             stall_i = 1'b0;
  logic             sentence_ok_o;
  logic             payload_valid_o;
  logic [CharW-1:0] payload_char_o;

  logic [CharW-1:0] cks_acc = '0;
  logic [TermW-1:0] term_no = '0;
  logic [OffsW-1:0] term_len = '0;
  logic [CharW-1:0] term_head [TermKeep] = '{default: '0};
  logic             in_cks_field = 1'b0;
  logic             vdo_seen = 1'b0;

  avsc_result_t     expected_q [$];
  logic [CharW-1:0] line_q [$];
  int               chars_sent = 0;
  int               error_count = 0;
  int               cycle_count = 0;
  int               stall_hold = 0;

  stim_row_t dir_rows [DirN] = '{
    '{8'h00,    1'b1, '{1'b0, 1'b0, 8'h00}},
    '{8'hFF,    1'b1, '{1'b0, 1'b0, 8'h00}},
    '{ChStart,  1'b1, '{1'b0, 1'b0, 8'h00}},
    '{"A",      1'b0, '{1'b0, 1'b0, 8'h00}},
    '{"I",      1'b0, '{1'b0, 1'b0, 8'h00}},
    '{"V",      1'b0, '{1'b0, 1'b0, 8'h00}},
    '{"D",      1'b0, '{1'b0, 1'b0, 8'h00}},
    '{"O",      1'b0, '{1'b0, 1'b0, 8'h00}},
    '{ChComma,  1'b0, '{1'b0, 1'b0, 8'h00}},
    '{ChComma,  1'b0, '{1'b0, 1'b0, 8'h00}},
    '{ChComma,  1'b0, '{1'b0, 1'b0, 8'h00}},
    '{ChComma,  1'b0, '{1'b0, 1'b0, 8'h00}},
    '{ChComma,  1'b0, '{1'b0, 1'b0, 8'h00}},
    '{"P",      1'b1, '{1'b0, 1'b1, "P"}},
    '{ChStar,   1'b0, '{1'b0, 1'b0, 8'h00}},
    '{"2",      1'b0, '{1'b0, 1'b0, 8'h00}},
    '{"9",      1'b0, '{1'b0, 1'b0, 8'h00}},
    '{ChCr,     1'b1, '{1'b1, 1'b0, 8'h00}},
    '{ChLf,     1'b0, '{1'b0, 1'b0, 8'h00}},
    '{ChStar,   1'b0, '{1'b0, 1'b0, 8'h00}},
    '{"5",      1'b0, '{1'b0, 1'b0, 8'h00}},
    '{ChComma,  1'b0, '{1'b0, 1'b0, 8'h00}},
    '{ChStart,  1'b1, '{1'b0, 1'b0, 8'h00}}
  };

  ais_vdo_sentence_checker_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .char_in_i      (char_in_i),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .sentence_ok_o  (sentence_ok_o),
    .payload_valid_o(payload_valid_o),
    .payload_char_o (payload_char_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [CharW-1:0] digit_value(input logic [CharW-1:0] c);
    if (c >= ChUpperA && c <= ChUpperF) return c - ChUpperA + 8'd10;
    if (c >= ChLowerA && c <= ChLowerF) return c - ChLowerA + 8'd10;
    return c - ChZero;
  endfunction

  function automatic avsc_result_t parse_char(input logic [CharW-1:0] c);
    avsc_result_t     r;
    logic [CharW-1:0] hi;
    logic [CharW-1:0] lo;
    logic [CharW-1:0] sum;
    r = '0;
    if (c == ChComma || c == ChCr || c == ChLf || c == ChStar) begin
      if (c == ChComma && !in_cks_field) cks_acc = cks_acc ^ c;
      if (in_cks_field) begin
        hi = digit_value((term_len > 0) ? term_head[0] : ChNul);
        lo = digit_value((term_len > 1) ? term_head[1] : ChNul);
        sum = {hi[3:0], 4'h0} + lo;
        r.sentence_ok = (sum == cks_acc) && vdo_seen;
      end else if (term_no == TermType && term_len == OffsKeep &&
                   term_head[0] >= ChUpperA && term_head[0] <= ChUpperZ &&
                   term_head[1] >= ChUpperA && term_head[1] <= ChUpperZ &&
                   term_head[2] == ChV && term_head[3] == ChD && term_head[4] == ChO) begin
        vdo_seen = 1'b1;
      end
      if (term_no < TermLimit) term_no = term_no + 1'b1;
      term_len = '0;
      in_cks_field = (c == ChStar);
    end else if (c == ChStart) begin
      vdo_seen = 1'b0;
      term_no = '0;
      term_len = '0;
      cks_acc = '0;
      in_cks_field = 1'b0;
    end else begin
      if (term_len < OffsKeep) begin
        term_head[term_len] = c;
        term_len = term_len + 1'b1;
      end else begin
        term_len = OffsLong;
      end
      if (!in_cks_field) begin
        cks_acc = cks_acc ^ c;
        if (vdo_seen && term_no == TermPayload) begin
          r.payload_valid = 1'b1;
          r.payload_char = c;
        end
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CharW-1:0] plain_char();
    logic [CharW-1:0] c;
    do begin
      if ($urandom_range(0, 9) < 8) c = 8'($urandom_range(8'h30, 8'h77));
      else c = 8'($urandom_range(0, 255));
    end while (c == ChComma || c == ChCr || c == ChLf || c == ChStar || c == ChStart);
    return c;
  endfunction

  function automatic logic [CharW-1:0] nibble_char(input logic [3:0] n);
    if (n < 10) return ChZero + 8'(n);
    if ($urandom_range(0, 1) == 1) return ChLowerA + 8'(n - 10);
    return ChUpperA + 8'(n - 10);
  endfunction

  task automatic build_sentence();
    logic [CharW-1:0] body [$];
    logic [CharW-1:0] sum;
    int               r;
    int               len;
    int               nterms;
    int               k;
    r = $urandom_range(0, 99);
    if (r < 15) repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(0, 255)));
    line_q.push_back(ChStart);
    r = $urandom_range(0, 99);
    if (r < 75) begin
      body.push_back(ChUpperA + 8'($urandom_range(0, 25)));
      body.push_back(ChUpperA + 8'($urandom_range(0, 25)));
      body.push_back(ChV);
      body.push_back(ChD);
      body.push_back(ChO);
    end else if (r < 90) begin
      body.push_back(plain_char());
      body.push_back(plain_char());
      body.push_back(ChV);
      body.push_back(ChD);
      body.push_back(($urandom_range(0, 1) == 1) ? ChO : plain_char());
      repeat ($urandom_range(0, 2)) body.push_back(plain_char());
    end else begin
      repeat ($urandom_range(0, 7)) body.push_back(plain_char());
    end
    r = $urandom_range(0, 9);
    if (r == 0) nterms = $urandom_range(0, 4);
    else if (r == 1) nterms = $urandom_range(7, 10);
    else nterms = $urandom_range(5, 6);
    for (k = 1; k <= nterms; k++) begin
      body.push_back(ChComma);
      len = (k == 5) ? $urandom_range(0, 12) : $urandom_range(0, 2);
      repeat (len) body.push_back(plain_char());
    end
    if ($urandom_range(0, 19) == 0) begin
      len = $urandom_range(0, body.size());
      while (body.size() > len) void'(body.pop_back());
      foreach (body[i]) line_q.push_back(body[i]);
      return;
    end
    sum = '0;
    foreach (body[i]) begin
      sum = sum ^ body[i];
      line_q.push_back(body[i]);
    end
    line_q.push_back(ChStar);
    r = $urandom_range(0, 99);
    if (r < 8) sum = sum ^ 8'($urandom_range(1, 255));
    line_q.push_back(nibble_char(sum[7:4]));
    if (r < 88) begin
      line_q.push_back(nibble_char(sum[3:0]));
    end else if (r >= 94) begin
      line_q.push_back(nibble_char(sum[3:0]));
      line_q.push_back(plain_char());
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      line_q.push_back(ChCr);
      line_q.push_back(ChLf);
    end else if (r < 85) begin
      line_q.push_back(ChLf);
    end else if (r < 95) begin
      line_q.push_back(ChComma);
    end
  endtask

  task automatic send_char(input logic [CharW-1:0] ch, input logic typed,
                           input avsc_result_t want);
    int           gap;
    avsc_result_t got;
    gap = ((chars_sent / 80) % 5 == 4) ? 0 : pick_gap();
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    char_in_i <= ch;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    got = parse_char(ch);
    expected_q.push_back(typed ? want : got);
    chars_sent++;
  endtask

  initial begin : stimulus
    int idx;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (idx = 0; idx < DirN; idx++) begin
      send_char(dir_rows[idx].ch, dir_rows[idx].typed, dir_rows[idx].want);
    end
    while (chars_sent < DirN + RandItems) begin
      build_sentence();
      while (line_q.size() > 0) send_char(line_q.pop_front(), 1'b0, '0);
    end
    valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(posedge clk_i) begin : result_check
    avsc_result_t want;
    int           g;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual %0b %0b %02h", $time,
                 sentence_ok_o, payload_valid_o, payload_char_o);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (sentence_ok_o !== want.sentence_ok) begin
          $display("%0t: sentence_ok expected %0b, actual %0b", $time,
                   want.sentence_ok, sentence_ok_o);
          error_count++;
        end
        if (payload_valid_o !== want.payload_valid) begin
          $display("%0t: payload_valid expected %0b, actual %0b", $time,
                   want.payload_valid, payload_valid_o);
          error_count++;
        end
        if (payload_char_o !== want.payload_char) begin
          $display("%0t: payload_char expected %02h, actual %02h", $time,
                   want.payload_char, payload_char_o);
          error_count++;
        end
      end
    end
    if (rst_ni) begin
      if (stall_hold > 0) begin
        stall_hold--;
      end else if (stall_i) begin
        stall_i <= 1'b0;
        stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(0, 5);
      end else if ($urandom_range(0, 99) < 40) begin
        g = pick_gap();
        if (g > 0) begin
          stall_i <= 1'b1;
          stall_hold = g - 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
